FILE: src/dbq_pkg.sv
// dbq_pkg: shared types, codes and constants of the delta bucket queue
// used by dbq_ctrl, dbq_dp and delta_bucket_queue; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dbq_pkg;

   // default sizes
   localparam int NUM_VERTICES_DEF = 1024;
   localparam int NUM_BUCKETS_DEF  = 64;

   // field widths
   localparam int REQ_W      = 2;
   localparam int VERTEX_W   = 10;
   localparam int DIST_W     = 32;
   localparam int STATUS_W   = 3;
   localparam int IDX_W      = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // bucket occupancy flags are searched this many at a time
   localparam int SCAN_GW = 8;

   localparam logic [CSR_DATA_W-1:0] BUCKET_WIDTH_RST = 32'h0001_0000;

   // register index, taken from address bit 2
   localparam logic REG_BUCKET_WIDTH = 1'b0;

   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_FIND   = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_ABSENT   = 3'd1,
      STAT_PRESENT  = 3'd2,
      STAT_OVERFLOW = 3'd3,
      STAT_EMPTY    = 3'd4
   } status_type;

   // where the result bucket number comes from
   typedef enum logic [1:0] {
      SRC_ZERO   = 2'd0,
      SRC_RECORD = 2'd1,
      SRC_TARGET = 2'd2,
      SRC_SCAN   = 2'd3
   } src_type;

   typedef enum logic [3:0] {
      S_CLEAR     = 4'd0,
      S_IDLE      = 4'd1,
      S_DECODE    = 4'd2,
      S_VB_CHECK  = 4'd3,
      S_DIV       = 4'd4,
      S_DIV_CHECK = 4'd5,
      S_COMMIT    = 4'd6,
      S_SCAN      = 4'd7,
      S_RESP      = 4'd8
   } state_type;

   typedef struct packed {
      logic       latch_req;
      logic       clear_step;
      logic       vb_read;
      logic       div_start;
      logic       div_step;
      logic       cnt_read;
      logic       commit_ins;
      logic       commit_rem;
      logic       scan_step;
      logic       load_rsp;
      status_type rsp_status;
      src_type    rsp_src;
   } cmd_type;

   typedef struct packed {
      req_code_type req_code;
      logic         vtx_in_range;
      logic         vb_valid;
      logic         div_last;
      logic         q_in_range;
      logic         scan_hit;
      logic         scan_last;
      logic         clear_last;
   } stat_type;

endpackage

`default_nettype wire

FILE: src/dbq_ram.sv
// dbq_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/dbq_ctrl.sv
// dbq_ctrl: sequencing state machine of the delta bucket queue
// depends on dbq_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire dbq_pkg::stat_type status,
   output      dbq_pkg::cmd_type  cmd
);

   dbq_pkg::state_type  state_ff, state_in;
   dbq_pkg::status_type code_ff, code_in;
   dbq_pkg::src_type    src_ff, src_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      src_in   = src_ff;
      case (state_ff)
         dbq_pkg::S_CLEAR: begin
            if (status.clear_last) begin
               state_in = dbq_pkg::S_IDLE;
            end
         end
         dbq_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = dbq_pkg::S_DECODE;
            end
         end
         dbq_pkg::S_DECODE: begin
            case (status.req_code)
               dbq_pkg::REQ_INSERT, dbq_pkg::REQ_REMOVE: begin
                  state_in = dbq_pkg::S_VB_CHECK;
               end
               dbq_pkg::REQ_FIND: begin
                  state_in = dbq_pkg::S_SCAN;
               end
               default: begin
                  state_in = dbq_pkg::S_RESP;
                  code_in  = dbq_pkg::STAT_OK;
                  src_in   = dbq_pkg::SRC_ZERO;
               end
            endcase
         end
         dbq_pkg::S_VB_CHECK: begin
            if (!status.vtx_in_range) begin
               state_in = dbq_pkg::S_RESP;
               code_in  = dbq_pkg::STAT_ABSENT;
               src_in   = dbq_pkg::SRC_ZERO;
            end else begin
               case (status.req_code)
                  dbq_pkg::REQ_INSERT: begin
                     if (status.vb_valid) begin
                        state_in = dbq_pkg::S_RESP;
                        code_in  = dbq_pkg::STAT_PRESENT;
                        src_in   = dbq_pkg::SRC_RECORD;
                     end else begin
                        state_in = dbq_pkg::S_DIV;
                     end
                  end
                  dbq_pkg::REQ_REMOVE: begin
                     if (status.vb_valid) begin
                        state_in = dbq_pkg::S_COMMIT;
                     end else begin
                        state_in = dbq_pkg::S_RESP;
                        code_in  = dbq_pkg::STAT_ABSENT;
                        src_in   = dbq_pkg::SRC_ZERO;
                     end
                  end
                  default: begin
                     state_in = dbq_pkg::S_RESP;
                     code_in  = dbq_pkg::STAT_OK;
                     src_in   = dbq_pkg::SRC_ZERO;
                  end
               endcase
            end
         end
         dbq_pkg::S_DIV: begin
            if (status.div_last) begin
               state_in = dbq_pkg::S_DIV_CHECK;
            end
         end
         dbq_pkg::S_DIV_CHECK: begin
            if (status.q_in_range) begin
               state_in = dbq_pkg::S_COMMIT;
            end else begin
               state_in = dbq_pkg::S_RESP;
               code_in  = dbq_pkg::STAT_OVERFLOW;
               src_in   = dbq_pkg::SRC_ZERO;
            end
         end
         dbq_pkg::S_COMMIT: begin
            state_in = dbq_pkg::S_RESP;
            code_in  = dbq_pkg::STAT_OK;
            src_in   = dbq_pkg::SRC_TARGET;
         end
         dbq_pkg::S_SCAN: begin
            if (status.scan_hit) begin
               state_in = dbq_pkg::S_RESP;
               code_in  = dbq_pkg::STAT_OK;
               src_in   = dbq_pkg::SRC_SCAN;
            end else if (status.scan_last) begin
               state_in = dbq_pkg::S_RESP;
               code_in  = dbq_pkg::STAT_EMPTY;
               src_in   = dbq_pkg::SRC_ZERO;
            end
         end
         dbq_pkg::S_RESP: begin
            if (slot_free) begin
               state_in = dbq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dbq_pkg::S_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd            = '0;
      cmd.rsp_status = code_ff;
      cmd.rsp_src    = src_ff;
      req_stall      = 1'b1;
      case (state_ff)
         dbq_pkg::S_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         dbq_pkg::S_IDLE: begin
            req_stall     = 1'b0;
            cmd.latch_req = req_valid;
         end
         dbq_pkg::S_DECODE: begin
            cmd.vb_read = 1'b1;
         end
         dbq_pkg::S_VB_CHECK: begin
            cmd.div_start = status.vtx_in_range && !status.vb_valid &&
                            (status.req_code == dbq_pkg::REQ_INSERT);
            cmd.cnt_read  = status.vtx_in_range && status.vb_valid &&
                            (status.req_code == dbq_pkg::REQ_REMOVE);
         end
         dbq_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
         end
         dbq_pkg::S_DIV_CHECK: begin
            cmd.cnt_read = status.q_in_range;
         end
         dbq_pkg::S_COMMIT: begin
            cmd.commit_ins = (status.req_code == dbq_pkg::REQ_INSERT);
            cmd.commit_rem = (status.req_code == dbq_pkg::REQ_REMOVE);
         end
         dbq_pkg::S_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         dbq_pkg::S_RESP: begin
            cmd.load_rsp = slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dbq_pkg::S_CLEAR;
         code_ff      <= dbq_pkg::STAT_OK;
         src_ff       <= dbq_pkg::SRC_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         src_ff       <= src_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: src/dbq_dp.sv
// dbq_dp: datapath of the delta bucket queue: vertex and count memories,
// occupancy flags, radix-2 divider, bucket scan and result register
// depends on dbq_pkg and dbq_ram
`timescale 1ns / 1ps
`default_nettype none

module dbq_dp #(
   parameter int NUM_VERTICES = dbq_pkg::NUM_VERTICES_DEF,
   parameter int NUM_BUCKETS  = dbq_pkg::NUM_BUCKETS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire dbq_pkg::cmd_type                 cmd,
   output      dbq_pkg::stat_type                status,
   input  wire logic [dbq_pkg::REQ_W-1:0]        req_type,
   input  wire logic [dbq_pkg::VERTEX_W-1:0]     req_vertex,
   input  wire logic [dbq_pkg::DIST_W-1:0]       req_distance,
   input  wire logic [dbq_pkg::CSR_DATA_W-1:0]   bucket_width,
   output      logic [dbq_pkg::STATUS_W-1:0]     rsp_status,
   output      logic [dbq_pkg::IDX_W-1:0]        rsp_bucket_index
);

   localparam int AW  = $clog2(NUM_VERTICES);
   localparam int BW  = $clog2(NUM_BUCKETS);
   localparam int VBW = BW + 1;
   localparam int CW  = $clog2(NUM_VERTICES + 1);
   localparam int NG  = (NUM_BUCKETS + dbq_pkg::SCAN_GW - 1) / dbq_pkg::SCAN_GW;
   localparam int SW  = (NG > 1) ? $clog2(NG) : 1;
   localparam int FW  = NG * dbq_pkg::SCAN_GW;
   localparam int PW  = $clog2(dbq_pkg::SCAN_GW);
   localparam int DCW = $clog2(dbq_pkg::DIST_W);

   // latched request
   dbq_pkg::req_code_type             req_code_ff;
   logic [dbq_pkg::VERTEX_W-1:0]      vertex_ff;
   logic [dbq_pkg::DIST_W-1:0]        dist_ff;

   // clearing sweep
   logic [AW-1:0]                     clr_ff;

   // divider
   logic [dbq_pkg::DIST_W-1:0]        quot_ff, quot_in;
   logic [dbq_pkg::DIST_W-1:0]        rem_ff, rem_in;
   logic [DCW-1:0]                    div_cnt_ff;
   logic [dbq_pkg::DIST_W:0]          shifted, diff;

   // occupancy and scan
   logic [FW-1:0]                     flag_ff;
   logic [SW-1:0]                     scan_ff;
   logic [BW-1:0]                     scan_idx_ff;
   logic [dbq_pkg::SCAN_GW-1:0]       grp;
   logic [PW-1:0]                     grp_pos;

   // result
   dbq_pkg::status_type               rsp_status_ff;
   logic [dbq_pkg::IDX_W-1:0]         rsp_idx_ff, rsp_idx_in;

   // memories
   logic [AW-1:0]                     vaddr;
   logic                              vb_we;
   logic [AW-1:0]                     vb_waddr;
   logic [VBW-1:0]                    vb_wdata, vb_rdata;
   logic [BW-1:0]                     rec_bkt, target;
   logic                              cnt_we;
   logic [CW-1:0]                     cnt_wdata, cnt_rdata, cnt_eff;
   logic                              dec_ok;

   assign vaddr   = AW'(vertex_ff);
   assign rec_bkt = vb_rdata[BW-1:0];
   assign target  = (req_code_ff == dbq_pkg::REQ_INSERT) ? quot_ff[BW-1:0] : rec_bkt;

   // a bucket without its flag holds no members, whatever the ram says
   assign cnt_eff = flag_ff[target] ? cnt_rdata : '0;
   assign dec_ok  = flag_ff[target] && (cnt_eff != '0);

   assign vb_we    = cmd.clear_step || cmd.commit_ins || cmd.commit_rem;
   assign vb_waddr = cmd.clear_step ? clr_ff : vaddr;
   assign vb_wdata = cmd.commit_ins ? {1'b1, target} : '0;

   assign cnt_we    = cmd.commit_ins || (cmd.commit_rem && dec_ok);
   assign cnt_wdata = cmd.commit_ins ? (cnt_eff + CW'(1)) : (cnt_eff - CW'(1));

   dbq_ram #(
      .WIDTH (VBW),
      .DEPTH (NUM_VERTICES)
   ) u_vb_ram (
      .clock   (clock),
      .wr_en   (vb_we),
      .wr_addr (vb_waddr),
      .wr_data (vb_wdata),
      .rd_en   (cmd.vb_read),
      .rd_addr (vaddr),
      .rd_data (vb_rdata)
   );

   dbq_ram #(
      .WIDTH (CW),
      .DEPTH (NUM_BUCKETS)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (target),
      .wr_data (cnt_wdata),
      .rd_en   (cmd.cnt_read),
      .rd_addr (target),
      .rd_data (cnt_rdata)
   );

   // restoring divide step, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quot_ff[dbq_pkg::DIST_W-1]};
      diff    = shifted - {1'b0, bucket_width};
      if (!diff[dbq_pkg::DIST_W]) begin
         rem_in  = diff[dbq_pkg::DIST_W-1:0];
         quot_in = {quot_ff[dbq_pkg::DIST_W-2:0], 1'b1};
      end else begin
         rem_in  = shifted[dbq_pkg::DIST_W-1:0];
         quot_in = {quot_ff[dbq_pkg::DIST_W-2:0], 1'b0};
      end
   end

   // lowest set flag of the current group
   assign grp = flag_ff[scan_ff * dbq_pkg::SCAN_GW +: dbq_pkg::SCAN_GW];

   always_comb begin
      grp_pos = '0;
      for (int i = dbq_pkg::SCAN_GW - 1; i >= 0; i--) begin
         if (grp[i]) begin
            grp_pos = PW'(i);
         end
      end
   end

   always_comb begin
      case (cmd.rsp_src)
         dbq_pkg::SRC_RECORD: rsp_idx_in = dbq_pkg::IDX_W'(rec_bkt);
         dbq_pkg::SRC_TARGET: rsp_idx_in = dbq_pkg::IDX_W'(target);
         dbq_pkg::SRC_SCAN:   rsp_idx_in = dbq_pkg::IDX_W'(scan_idx_ff);
         default:             rsp_idx_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         flag_ff <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (cmd.commit_ins) begin
            flag_ff[target] <= 1'b1;
         end else if (cmd.commit_rem && dec_ok && (cnt_eff == CW'(1))) begin
            flag_ff[target] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_code_ff <= dbq_pkg::req_code_type'(req_type);
         vertex_ff   <= req_vertex;
         dist_ff     <= req_distance;
         scan_ff     <= '0;
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + SW'(1);
      end
      if (cmd.scan_step && (grp != '0)) begin
         scan_idx_ff <= BW'({scan_ff, grp_pos});
      end
      if (cmd.div_start) begin
         quot_ff    <= dist_ff;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quot_ff    <= quot_in;
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_ff + DCW'(1);
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_idx_ff    <= rsp_idx_in;
      end
   end

   assign status.req_code     = req_code_ff;
   assign status.vtx_in_range = 32'(vertex_ff) < 32'(NUM_VERTICES);
   assign status.vb_valid     = vb_rdata[VBW-1];
   assign status.div_last     = (div_cnt_ff == DCW'(dbq_pkg::DIST_W - 1));
   assign status.q_in_range   = quot_ff < 32'(NUM_BUCKETS);
   assign status.scan_hit     = (grp != '0);
   assign status.scan_last    = (scan_ff == SW'(NG - 1));
   assign status.clear_last   = (clr_ff == AW'(NUM_VERTICES - 1));

   assign rsp_status       = rsp_status_ff;
   assign rsp_bucket_index = rsp_idx_ff;

endmodule

`default_nettype wire

FILE: src/delta_bucket_queue.sv
// delta_bucket_queue: top level, configuration register and block assembly
// depends on dbq_pkg, dbq_ctrl, dbq_dp and dbq_ram
`timescale 1ns / 1ps
`default_nettype none

// Bucket queue for delta-stepping: each vertex records the bucket it sits in
// and each bucket keeps a member count plus an occupancy flag. One request is
// handled at a time and each request gives one result word. An insert runs the
// 32-step radix-2 divider that forms floor(distance / bucket_width); a duplicate
// insert skips it, and an insert whose bucket lies beyond the last one still
// runs the full divide. A remove reads the vertex memory, reads the count
// memory and writes back; an absent vertex skips the count read and write back.
// A find searches the occupancy flags eight buckets per cycle. The next
// request is taken in the cycle after a result is loaded. After reset the vertex
// memory is swept clear, one entry a cycle, during which req_stall stays high;
// bucket_width may be written at any time while no request is open. The result
// sits in an output register, so the next request is taken while a finished
// result still waits on rsp_stall.
module delta_bucket_queue #(
   parameter int NUM_VERTICES = dbq_pkg::NUM_VERTICES_DEF,
   parameter int NUM_BUCKETS  = dbq_pkg::NUM_BUCKETS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   // request words
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic [dbq_pkg::REQ_W-1:0]          req_type,
   input  wire logic [dbq_pkg::VERTEX_W-1:0]       req_vertex,
   input  wire logic [dbq_pkg::DIST_W-1:0]         req_distance,

   // result words
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic [dbq_pkg::STATUS_W-1:0]       rsp_status,
   output      logic [dbq_pkg::IDX_W-1:0]          rsp_bucket_index,

   // register access
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [dbq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [dbq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [dbq_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output      logic                               csr_pready
);

   dbq_pkg::cmd_type                   cmd;
   dbq_pkg::stat_type                  status;
   logic [dbq_pkg::CSR_DATA_W-1:0]     bucket_width_ff;
   logic                               csr_wr;
   logic                               csr_sel_bw;

   // register block: single register at word 0, no wait states
   assign csr_pready = 1'b1;
   assign csr_sel_bw = (csr_paddr[2] == dbq_pkg::REG_BUCKET_WIDTH);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_sel_bw ? bucket_width_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_width_ff <= dbq_pkg::BUCKET_WIDTH_RST;
      end else if (csr_wr && csr_sel_bw) begin
         bucket_width_ff <= csr_pwdata;
      end
   end

   // sequencer
   dbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // memories, divider, scan and result register
   dbq_dp #(
      .NUM_VERTICES (NUM_VERTICES),
      .NUM_BUCKETS  (NUM_BUCKETS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_type         (req_type),
      .req_vertex       (req_vertex),
      .req_distance     (req_distance),
      .bucket_width     (bucket_width_ff),
      .rsp_status       (rsp_status),
      .rsp_bucket_index (rsp_bucket_index)
   );

`ifndef SYNTH
   // a result word only appears after the controller loaded it
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_rsp))
      else $error("result word appeared without a load");

   // count update always uses data read the cycle before
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_ins || cmd.commit_rem) |-> $past(cmd.cnt_read))
      else $error("commit without a preceding count read");

   // divider runs right after it is loaded
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> cmd.div_step)
      else $error("divider loaded but not stepped");

   // empty report carries bucket zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == dbq_pkg::STAT_EMPTY)) |-> (rsp_bucket_index == '0))
      else $error("empty result with nonzero bucket");
`endif

endmodule

`default_nettype wire

FILE: test/delta_bucket_queue_check.sv
// delta_bucket_queue_check: watches the request, result and register ports of
// the delta bucket queue, keeps its own bucket state and checks every result word
// depends on dbq_pkg
`timescale 1ns / 1ps

module delta_bucket_queue_check #(
   parameter int NUM_VERTICES = dbq_pkg::NUM_VERTICES_DEF,
   parameter int NUM_BUCKETS  = dbq_pkg::NUM_BUCKETS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [dbq_pkg::REQ_W-1:0]          req_type,
   input  logic [dbq_pkg::VERTEX_W-1:0]       req_vertex,
   input  logic [dbq_pkg::DIST_W-1:0]         req_distance,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [dbq_pkg::STATUS_W-1:0]       rsp_status,
   input  logic [dbq_pkg::IDX_W-1:0]          rsp_bucket_index,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dbq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dbq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   input  logic                               csr_pready,
   output int                                 replies_left,
   output int                                 mismatches
);
   import dbq_pkg::*;

   typedef struct packed {
      status_type             status;
      logic [IDX_W-1:0]       bucket;
   } bucket_reply_type;

   logic                    on_list [NUM_VERTICES];
   logic [IDX_W-1:0]        home_bucket [NUM_VERTICES];
   logic [10:0]             members [NUM_BUCKETS];
   logic [CSR_DATA_W-1:0]   delta;
   bucket_reply_type        replies_due [$];
   bucket_reply_type        want;

   initial begin
      replies_left = 0;
      mismatches = 0;
   end

   task automatic log_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   // one request applied to the local bucket state
   function automatic bucket_reply_type bucket_op(input logic [REQ_W-1:0] kind,
                                                  input logic [VERTEX_W-1:0] vtx,
                                                  input logic [DIST_W-1:0] dist_val);
      bucket_reply_type r;
      logic [DIST_W-1:0] q;
      int b;
      r.status = STAT_OK;
      r.bucket = '0;
      case (kind)
         REQ_INSERT: begin
            q = (delta == '0) ? '1 : dist_val / delta;
            if (vtx >= NUM_VERTICES)
               r.status = STAT_ABSENT;
            else if (on_list[vtx]) begin
               r.status = STAT_PRESENT;
               r.bucket = home_bucket[vtx];
            end else if (q >= NUM_BUCKETS)
               r.status = STAT_OVERFLOW;
            else begin
               on_list[vtx] = 1'b1;
               home_bucket[vtx] = IDX_W'(q);
               members[q] = members[q] + 1'b1;
               r.bucket = IDX_W'(q);
            end
         end
         REQ_REMOVE: begin
            if (vtx >= NUM_VERTICES || !on_list[vtx])
               r.status = STAT_ABSENT;
            else begin
               r.bucket = home_bucket[vtx];
               if (members[home_bucket[vtx]] != '0)
                  members[home_bucket[vtx]] = members[home_bucket[vtx]] - 1'b1;
               on_list[vtx] = 1'b0;
               home_bucket[vtx] = '0;
            end
         end
         REQ_FIND: begin
            r.status = STAT_EMPTY;
            for (b = NUM_BUCKETS - 1; b >= 0; b--) begin
               if (members[b] != '0) begin
                  r.status = STAT_OK;
                  r.bucket = IDX_W'(b);
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VERTICES; i++) begin
            on_list[i] = 1'b0;
            home_bucket[i] = '0;
         end
         for (int i = 0; i < NUM_BUCKETS; i++)
            members[i] = '0;
         delta = BUCKET_WIDTH_RST;
         replies_due.delete();
      end else begin
         // result side first: a word never answers a request taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0)
               log_mismatch($sformatf("result word status %0d bucket %0d with none due",
                                      rsp_status, rsp_bucket_index));
            else begin
               want = replies_due.pop_front();
               if (rsp_status !== want.status)
                  log_mismatch($sformatf("status %0d, expected %0d", rsp_status,
                                         want.status));
               if (rsp_bucket_index !== want.bucket)
                  log_mismatch($sformatf("bucket %0d, expected %0d", rsp_bucket_index,
                                         want.bucket));
            end
         end
         if (req_valid && !req_stall)
            replies_due.insert(replies_due.size(),
                               bucket_op(req_type, req_vertex, req_distance));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == REG_BUCKET_WIDTH)
            delta = csr_pwdata;
      end
      replies_left <= replies_due.size();
   end

endmodule

FILE: test/delta_bucket_queue_test.sv
// delta_bucket_queue_test: stimulus, stall patterns and verdict for the delta
// bucket queue; depends on dbq_pkg, delta_bucket_queue and delta_bucket_queue_check
`timescale 1ns / 1ps

module delta_bucket_queue_test;
   import dbq_pkg::*;

   // request code the block does not define
   localparam logic [REQ_W-1:0]      REQ_UNUSED = 2'd3;
   // byte address of the bucket width register
   localparam logic [CSR_ADDR_W-1:0] ADDR_BUCKET_WIDTH = 3'd0;
   // idle cycles allowed before the run is declared hung, clear pass included
   localparam int IDLE_LIMIT = 5000;
   // cycles per receiver stall pattern
   localparam int PATTERN_SPAN = 500;

   typedef enum int {
      STALL_NONE,
      STALL_COIN,
      STALL_RUNS,
      STALL_EVERY3
   } stall_mode_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [REQ_W-1:0]       req_type = REQ_INSERT;
   logic [VERTEX_W-1:0]    req_vertex = '0;
   logic [DIST_W-1:0]      req_distance = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [IDX_W-1:0]       rsp_bucket_index;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int                     replies_left;
   int                     mismatches;
   int                     idle_cycles = 0;
   int                     pattern_age = 0;
   int                     stall_run = 0;
   logic [CSR_DATA_W-1:0]  cur_width = BUCKET_WIDTH_RST;

   delta_bucket_queue u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_vertex       (req_vertex),
      .req_distance     (req_distance),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_bucket_index (rsp_bucket_index),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   delta_bucket_queue_check u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_vertex       (req_vertex),
      .req_distance     (req_distance),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_bucket_index (rsp_bucket_index),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .replies_left     (replies_left),
      .mismatches       (mismatches)
   );

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stall: four patterns take turns as pattern_age advances,
   // one of the patterns never stalls
   always @(negedge clock) begin
      pattern_age <= pattern_age + 1;
      case (stall_mode_type'((pattern_age / PATTERN_SPAN) % 4))
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_COIN: rsp_stall <= ($urandom_range(0, 1) == 1);
         STALL_RUNS: begin
            // long stall runs now and then, free otherwise
            if (stall_run > 0) begin
               rsp_stall <= 1'b1;
               stall_run <= stall_run - 1;
            end else begin
               rsp_stall <= 1'b0;
               if ($urandom_range(0, 5) == 0)
                  stall_run <= $urandom_range(1, 30);
            end
         end
         default: rsp_stall <= (pattern_age % 3 == 0);
      endcase
   end

   // hang detection: cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // present one request word and hold it until taken
   task automatic send_word(input logic [REQ_W-1:0] kind, input logic [VERTEX_W-1:0] vtx,
                            input logic [DIST_W-1:0] dist_val);
      @(negedge clock);
      req_valid <= 1'b1;
      req_type <= kind;
      req_vertex <= vtx;
      req_distance <= dist_val;
      @(posedge clock);
      while (!(req_valid && !req_stall))
         @(posedge clock);
   endtask

   // sender gap of a given number of cycles
   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // stop sending and wait until every result word is back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_left != 0)
         @(posedge clock);
   endtask

   // register write with setup and access cycles, only when no request is open
   task automatic write_bucket_width(input logic [CSR_DATA_W-1:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_BUCKET_WIDTH;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cur_width = value;
   endtask

   // distance aimed at a bucket near the valid range, sometimes fully random
   function automatic logic [DIST_W-1:0] pick_distance(input logic [CSR_DATA_W-1:0] w);
      logic [63:0] lo;
      logic [63:0] hi;
      int unsigned target;
      if (w == '0 || $urandom_range(0, 7) == 0)
         return $urandom();
      target = $urandom_range(0, 69);
      lo = 64'(target) * 64'(w);
      hi = lo + 64'(w) - 64'd1;
      if (hi > 64'hFFFF_FFFF)
         return $urandom();
      return DIST_W'(lo + 64'($urandom_range(0, w - 1)));
   endfunction

   // one setting of the bucket width with random traffic in bursts
   task automatic run_phase(input logic [CSR_DATA_W-1:0] width, input int words,
                            input int pool);
      int burst_left;
      int pick;
      logic [VERTEX_W-1:0] vtx;
      burst_left = 0;
      write_bucket_width(width);
      for (int n = 0; n < words; n++) begin
         if (burst_left == 0) begin
            // now and then hold off until the block has answered everything
            if ($urandom_range(0, 29) == 0)
               wait_drained();
            pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) :
                         $urandom_range(1, 6));
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
         end
         burst_left--;
         // mostly a small vertex pool so duplicates and removes hit
         vtx = ($urandom_range(0, 3) == 0) ? VERTEX_W'($urandom_range(0, 1023)) :
                                             VERTEX_W'($urandom_range(0, pool - 1));
         pick = $urandom_range(0, 99);
         if (pick < 45)
            send_word(REQ_INSERT, vtx, pick_distance(cur_width));
         else if (pick < 75)
            send_word(REQ_REMOVE, vtx, $urandom());
         else if (pick < 95)
            send_word(REQ_FIND, VERTEX_W'($urandom()), $urandom());
         else
            send_word(REQ_UNUSED, VERTEX_W'($urandom()), $urandom());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at 1.0 bucket width
      write_bucket_width(BUCKET_WIDTH_RST);
      send_word(REQ_FIND, 10'd0, 32'd0);              // all buckets empty
      send_word(REQ_REMOVE, 10'd5, 32'd0);            // remove of absent vertex
      send_word(REQ_INSERT, 10'd0, 32'h0000_0000);    // lowest bucket
      send_word(REQ_INSERT, 10'd1023, 32'h003F_FFFF); // highest bucket
      send_word(REQ_INSERT, 10'd2, 32'h0040_0000);    // one past the last bucket
      send_word(REQ_INSERT, 10'd3, 32'hFFFF_FFFF);    // largest distance
      send_word(REQ_INSERT, 10'd0, 32'h0001_0000);    // duplicate, keeps bucket 0
      send_word(REQ_INSERT, 10'd1023, 32'h0);         // duplicate, keeps bucket 63
      send_word(REQ_FIND, 10'd1023, 32'hFFFF_FFFF);
      send_word(REQ_REMOVE, 10'd0, 32'hFFFF_FFFF);    // distance ignored
      send_word(REQ_FIND, 10'd0, 32'd0);              // now the top bucket
      send_word(REQ_REMOVE, 10'd0, 32'd0);            // second remove finds nothing
      send_word(REQ_UNUSED, 10'd1023, 32'hFFFF_FFFF); // unused code, no change
      send_word(REQ_INSERT, 10'd512, 32'h0005_5555);  // fractional distance, bucket 5
      send_word(REQ_FIND, 10'd0, 32'd0);
      send_word(REQ_REMOVE, 10'd1023, 32'd0);
      send_word(REQ_REMOVE, 10'd512, 32'd0);
      send_word(REQ_FIND, 10'd0, 32'd0);              // empty again

      // zero width: every insert overflows
      write_bucket_width(32'h0000_0000);
      send_word(REQ_INSERT, 10'd7, 32'h0000_0000);
      send_word(REQ_INSERT, 10'd8, 32'hFFFF_FFFF);
      send_word(REQ_FIND, 10'd0, 32'd0);

      // random phases across widths, extremes included
      run_phase(BUCKET_WIDTH_RST, 300, 64);
      run_phase(32'h0000_0001, 200, 48);
      run_phase(32'hFFFF_FFFF, 250, 400);
      run_phase(32'h0000_0000, 40, 32);
      run_phase(32'h0001_8000, 250, 96);
      run_phase($urandom_range(2, 32'hFFFF_FFFE), 250, 64);
      run_phase(32'h0000_4000, 200, 1024);

      // let the last results come back, then a short settle
      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
